>>> hdl/bba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy allocator package
// Field widths and node state codes shared by the allocator files.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int MAX_DEPTH = 10;

  localparam int FUNC_W = 1;
  localparam int SIZE_W = 12;
  localparam int POS_W  = 10;
  localparam int NODE_W = 11;
  localparam int OFF_W  = 10;
  localparam int CFG_W  = 4;

  typedef logic [1:0] nstate_t;

  localparam nstate_t ST_FREE  = 2'd0;
  localparam nstate_t ST_ALLOC = 2'd1;
  localparam nstate_t ST_SPLIT = 2'd2;
  localparam nstate_t ST_FULL  = 2'd3;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

endpackage

>>> hdl/bba_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy allocator channels
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bba_req_if import bba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [SIZE_W-1:0] request_size;
  logic [POS_W-1:0]  position;
  modport source (output valid, func, request_size, position, input ready);
  modport sink (input valid, func, request_size, position, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              status;
  logic [NODE_W-1:0] node_index;
  logic [OFF_W-1:0]  block_offset;
  modport source (output valid, status, node_index, block_offset, input ready);
  modport sink (input valid, status, node_index, block_offset, output ready);
endinterface

interface bba_cfg_if import bba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> hdl/bba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 2047
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/buddy_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy block allocator
// Binary tree buddy allocator with node states kept in a RAM and walked
// by a small sequencer, one tree access per cycle.
// ----------------------------------------------------------------------------
// Channel  Dir  Word
// req      in   func, request_size, position
// rsp      out  status, node_index, block_offset
// cfg      in   tree_depth
//
// A request reads each tree node and then evaluates it, writes both children of
// a split node in turn, climbs one level per backtracking step, and is accepted
// and loaded into rsp in states of its own, all set by the single RAM read port.
// After reset and after every cfg write the RAM is cleared node by node,
// during which req and cfg are not ready.
// A stalled rsp word holds; the next request is taken while it waits.
// ----------------------------------------------------------------------------
module buddy_block_allocator import bba_pkg::*; (
  input  logic clk,
  input  logic rst,
  bba_req_if.sink   req,
  bba_rsp_if.source rsp,
  bba_cfg_if.sink   cfg
);

  localparam int AW         = MAX_DEPTH + 1;
  localparam int NODE_COUNT = (1 << (MAX_DEPTH + 1)) - 1;
  localparam int LW         = $clog2(MAX_DEPTH + 1) + 1;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_ARD  = 4'd2;
  localparam logic [3:0] S_AEV  = 4'd3;
  localparam logic [3:0] S_SPL1 = 4'd4;
  localparam logic [3:0] S_SPL2 = 4'd5;
  localparam logic [3:0] S_AUP  = 4'd6;
  localparam logic [3:0] S_MRD  = 4'd7;
  localparam logic [3:0] S_MEV  = 4'd8;
  localparam logic [3:0] S_FRD  = 4'd9;
  localparam logic [3:0] S_FEV  = 4'd10;
  localparam logic [3:0] S_GRD  = 4'd11;
  localparam logic [3:0] S_GEV  = 4'd12;
  localparam logic [3:0] S_HRD  = 4'd13;
  localparam logic [3:0] S_HEV  = 4'd14;
  localparam logic [3:0] S_DONE = 4'd15;

  logic [3:0]        state, state_next;
  logic [CFG_W-1:0]  tree_depth;
  logic [AW-1:0]     clr_cnt;
  logic [AW-1:0]     idx, idx_next;
  logic [LW-1:0]     lvl, lvl_next;
  logic [LW-1:0]     tgt, tgt_next;
  logic [LW-1:0]     dep, dep_next;
  logic [AW-1:0]     left, left_next;
  logic [POS_W-1:0]  pos_r, pos_next;
  logic              res_ok, res_ok_next;
  logic [NODE_W-1:0] res_node, res_node_next;
  logic [OFF_W-1:0]  res_off, res_off_next;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  nstate_t           wdata, rdata;

  logic [AW-1:0]     parent, buddy, child1, child2;
  logic [LW-1:0]     dsel;
  logic [SIZE_W-1:0] sm1;
  logic [3:0]        kval;
  logic [31:0]       half_w, off_w;

  bba_ram #(.WIDTH(2), .DEPTH(NODE_COUNT)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign parent = (idx - AW'(1)) >> 1;
  assign buddy  = idx[0] ? idx + AW'(1) : idx - AW'(1);
  assign child1 = {idx[AW-2:0], 1'b1};
  assign child2 = child1 + AW'(1);
  assign dsel   = (int'(tree_depth) > MAX_DEPTH) ? LW'(MAX_DEPTH) : LW'(tree_depth);
  assign sm1    = (req.request_size == '0) ? '0 : req.request_size - SIZE_W'(1);
  assign half_w = 32'(1) << (dep - lvl - LW'(1));
  assign off_w  = (32'(idx) - ((32'(1) << lvl) - 32'(1))) << (dep - lvl);

  always_comb begin
    kval = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (sm1[i]) begin
        kval = 4'(i + 1);
      end
    end
  end

  assign req.ready = (state == S_IDLE) && !cfg.valid;
  assign cfg.ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    lvl_next      = lvl;
    tgt_next      = tgt;
    dep_next      = dep;
    left_next     = left;
    pos_next      = pos_r;
    res_ok_next   = res_ok;
    res_node_next = res_node;
    res_off_next  = res_off;
    we            = 1'b0;
    waddr         = idx;
    wdata         = ST_FREE;
    raddr         = idx;
    unique case (state)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_cnt;
        if (int'(clr_cnt) == NODE_COUNT - 1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.valid && !cfg.valid) begin
          dep_next      = dsel;
          idx_next      = '0;
          lvl_next      = '0;
          left_next     = '0;
          pos_next      = req.position;
          res_ok_next   = 1'b0;
          res_node_next = '0;
          res_off_next  = '0;
          if (req.func == FUNC_ALLOC) begin
            tgt_next = dsel - LW'(kval);
            state_next = (int'(kval) > int'(dsel)) ? S_DONE : S_ARD;
          end else begin
            state_next = (32'(req.position) >= (32'(1) << dsel)) ? S_DONE : S_FRD;
          end
        end
      end
      S_ARD: begin
        state_next = S_AEV;
      end
      S_AEV: begin
        if (lvl == tgt && rdata == ST_FREE) begin
          we            = 1'b1;
          wdata         = ST_ALLOC;
          res_ok_next   = 1'b1;
          res_node_next = NODE_W'(idx);
          res_off_next  = off_w[OFF_W-1:0];
          state_next    = S_MRD;
        end else if (lvl != tgt && rdata == ST_FREE) begin
          we         = 1'b1;
          wdata      = ST_SPLIT;
          state_next = S_SPL1;
        end else if (lvl != tgt && rdata == ST_SPLIT) begin
          idx_next   = child1;
          lvl_next   = lvl + LW'(1);
          state_next = S_ARD;
        end else if (idx[0]) begin
          idx_next   = idx + AW'(1);
          state_next = S_ARD;
        end else begin
          state_next = S_AUP;
        end
      end
      S_SPL1: begin
        we         = 1'b1;
        waddr      = child1;
        state_next = S_SPL2;
      end
      S_SPL2: begin
        we         = 1'b1;
        waddr      = child2;
        idx_next   = child1;
        lvl_next   = lvl + LW'(1);
        state_next = S_ARD;
      end
      S_AUP: begin
        if (idx == '0) begin
          state_next = S_DONE;
        end else begin
          lvl_next = lvl - LW'(1);
          if (parent[0]) begin
            idx_next   = parent + AW'(1);
            state_next = S_ARD;
          end else begin
            idx_next = parent;
          end
        end
      end
      S_MRD: begin
        raddr      = buddy;
        state_next = (idx == '0) ? S_DONE : S_MEV;
      end
      S_MEV: begin
        if (rdata != ST_ALLOC && rdata != ST_FULL) begin
          state_next = S_DONE;
        end else begin
          we         = 1'b1;
          waddr      = parent;
          wdata      = ST_FULL;
          idx_next   = parent;
          state_next = S_MRD;
        end
      end
      S_FRD: begin
        state_next = S_FEV;
      end
      S_FEV: begin
        if (rdata == ST_FREE) begin
          state_next = S_DONE;
        end else if (rdata == ST_ALLOC) begin
          res_ok_next   = 1'b1;
          res_node_next = NODE_W'(idx);
          res_off_next  = OFF_W'(left);
          state_next    = S_GRD;
        end else if (lvl >= dep) begin
          state_next = S_DONE;
        end else begin
          lvl_next   = lvl + LW'(1);
          state_next = S_FRD;
          if (32'(pos_r) < 32'(left) + half_w) begin
            idx_next = child1;
          end else begin
            idx_next  = child2;
            left_next = left + AW'(half_w);
          end
        end
      end
      S_GRD: begin
        raddr = buddy;
        if (idx == '0) begin
          we         = 1'b1;
          state_next = S_HRD;
        end else begin
          state_next = S_GEV;
        end
      end
      S_GEV: begin
        we = 1'b1;
        if (rdata != ST_FREE) begin
          state_next = S_HRD;
        end else begin
          idx_next   = parent;
          state_next = S_GRD;
        end
      end
      S_HRD: begin
        raddr = parent;
        if (idx == '0) begin
          state_next = S_DONE;
        end else begin
          idx_next   = parent;
          state_next = S_HEV;
        end
      end
      S_HEV: begin
        if (rdata != ST_FULL) begin
          state_next = S_DONE;
        end else begin
          we         = 1'b1;
          wdata      = ST_SPLIT;
          state_next = S_HRD;
        end
      end
      S_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_cnt    <= '0;
      tree_depth <= CFG_W'(10);
      rsp.valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (cfg.valid && cfg.ready) begin
        tree_depth <= cfg.data;
        state      <= S_CLR;
        clr_cnt    <= '0;
      end
      if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    lvl      <= lvl_next;
    tgt      <= tgt_next;
    dep      <= dep_next;
    left     <= left_next;
    pos_r    <= pos_next;
    res_ok   <= res_ok_next;
    res_node <= res_node_next;
    res_off  <= res_off_next;
    if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.status       <= !res_ok;
      rsp.node_index   <= res_node;
      rsp.block_offset <= res_off;
    end
  end

endmodule

>>> hdl/bba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy allocator checker
// Port-level assertions, bound to the allocator top level.
// ----------------------------------------------------------------------------
module bba_checker import bba_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic              rsp_status,
  input logic [NODE_W-1:0] rsp_node_index,
  input logic [OFF_W-1:0]  rsp_block_offset,
  input logic              cfg_ready
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid && !req_ready)
    else $error("Response valid or request ready right after reset.");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_node_index) && $stable(rsp_block_offset))
    else $error("Stalled response word changed.");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status |-> rsp_node_index == '0 && rsp_block_offset == '0)
    else $error("Failed response carries a node or offset.");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready && !cfg_ready)
    else $error("Ready again in the cycle after a request was taken.");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_node_index   (rsp.node_index),
  .rsp_block_offset (rsp.block_offset),
  .cfg_ready        (cfg.ready)
);
